>>> hw/rtl/bsh_pkg.sv
// ----------------------------------------------------------------------------
// Backend selector package
// Shared widths, codes and types for the backend selector.
// ----------------------------------------------------------------------------
package bsh_pkg;

    localparam int MAX_BACKENDS = 8;
    localparam int WEIGHT_BITS  = 4;
    localparam int IDX_W        = 3;
    localparam int CNT_W        = 4;
    localparam int SUM_W        = 7;

    localparam logic [1:0] CFG_STRATEGY  = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_COUNT     = 2'd2;
    localparam logic [1:0] CFG_WEIGHTS   = 2'd3;

    localparam logic [2:0] OP_SELECT    = 3'd0;
    localparam logic [2:0] OP_SUCCESS   = 3'd1;
    localparam logic [2:0] OP_FAILURE   = 3'd2;
    localparam logic [2:0] OP_HLTH_PASS = 3'd3;
    localparam logic [2:0] OP_HLTH_FAIL = 3'd4;

    localparam logic [1:0] STRAT_RR  = 2'd0;
    localparam logic [1:0] STRAT_LC  = 2'd1;
    localparam logic [1:0] STRAT_WRR = 2'd2;

    localparam logic [1:0] ST_SELECTED  = 2'd0;
    localparam logic [1:0] ST_NONE      = 2'd1;
    localparam logic [1:0] ST_UPDATED   = 2'd2;

    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_DOWN      = 2'd1;
    localparam logic [1:0] EV_UP        = 2'd2;

    typedef struct packed {
        logic [2:0] operation;
        logic [2:0] target_backend;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] chosen_backend;
        logic [1:0] health_event;
    } t_rsp;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [SUM_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [SUM_W-1:0] remainder;
    } t_div_rsp;

endpackage

>>> hw/rtl/bsh_if.sv
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface bsh_req_if import bsh_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bsh_rsp_if import bsh_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/backend_selector_with_health.sv
// ----------------------------------------------------------------------------
// Backend selector with health tracking
// Picks a backend per select request and keeps per-backend health and load.
// ----------------------------------------------------------------------------
//  channel   | dir | payload
//  s_req     | in  | operation, target_backend
//  m_rsp     | out | status, chosen_backend, health_event
//  cfg       | in  | i_cfg_we, i_cfg_idx, i_cfg_data
//
//  An update, or a select with no healthy backend or strategy 3, goes straight
//  from the scan to the response; least connections walks the backends first.
//  Round robin, and weighted round robin with a nonzero weight sum, also pass
//  through the serial modulo unit.
//  Reset is synchronous and active low and restores every backend to healthy.
//  One request is in work at a time; a stalled response holds the block.
module backend_selector_with_health import bsh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    bsh_req_if.sink     s_req,
    bsh_rsp_if.source   m_rsp
);
    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_WSUM, S_WDIV, S_WWALK, S_PICK, S_OUT
    } t_state;

    t_state            r_state;
    logic [1:0]        r_strategy;
    logic [15:0]       r_thresh;
    logic [3:0]        r_bcount;
    logic [31:0]       r_weights;
    logic [MAX_BACKENDS-1:0] r_healthy;
    logic [15:0]       r_active [MAX_BACKENDS];
    logic [31:0]       r_total  [MAX_BACKENDS];
    logic [15:0]       r_consec [MAX_BACKENDS];
    logic [31:0]       r_rot;
    t_req              r_req;
    t_rsp              r_rsp;
    logic [CNT_W-1:0]  r_i;
    logic [CNT_W-1:0]  r_k;
    logic [IDX_W-1:0]  r_best;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  r_pos;
    logic              r_div_start;
    t_div_req          n_div;
    t_div_rsp          w_div;

    logic [CNT_W-1:0]  w_n;
    logic [IDX_W-1:0]  w_first;
    logic              w_any;
    logic [IDX_W-1:0]  w_i;
    logic [WEIGHT_BITS-1:0] w_wt;
    logic [CNT_W-1:0]  w_rr_idx;
    logic [31:0]       w_rot1;

    always_comb begin
        if (r_bcount == 4'd0) begin
            w_n = 4'd1;
        end else if (r_bcount > 4'(MAX_BACKENDS)) begin
            w_n = 4'(MAX_BACKENDS);
        end else begin
            w_n = r_bcount;
        end
        w_any   = 1'b0;
        w_first = '0;
        for (int j = MAX_BACKENDS - 1; j >= 0; j--) begin
            if (r_healthy[j] && (4'(j) < w_n)) begin
                w_any   = 1'b1;
                w_first = IDX_W'(j);
            end
        end
        w_i  = r_i[IDX_W-1:0];
        w_wt = r_weights[WEIGHT_BITS*w_i +: WEIGHT_BITS];
    end

    assign w_rot1   = r_rot + 32'd1;
    assign w_rr_idx = CNT_W'(r_i + 4'd1 == w_n ? 4'd0 : r_i + 4'd1);

    assign n_div.start    = r_div_start;
    assign n_div.dividend = (r_strategy == STRAT_RR) ? w_rot1 : r_rot;
    assign n_div.divisor  = r_sum;

    bsh_mod u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (n_div),
        .o_rsp  (w_div)
    );

    assign s_req.ready = (r_state == S_IDLE);
    assign m_rsp.valid = (r_state == S_OUT);
    assign m_rsp.data  = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_strategy  <= STRAT_RR;
            r_thresh    <= 16'd3;
            r_bcount    <= 4'd8;
            r_weights   <= 32'h1111_1111;
            r_healthy   <= '1;
            r_rot       <= '0;
            r_div_start <= 1'b0;
            for (int j = 0; j < MAX_BACKENDS; j++) begin
                r_active[j] <= '0;
                r_total[j]  <= '0;
                r_consec[j] <= '0;
            end
        end else begin
            r_div_start <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STRATEGY:  r_strategy <= i_cfg_data[1:0];
                    CFG_THRESHOLD: r_thresh   <= i_cfg_data[15:0];
                    CFG_COUNT:     r_bcount   <= i_cfg_data[3:0];
                    CFG_WEIGHTS:   r_weights  <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (s_req.valid) begin
                        r_req <= s_req.data;
                        r_rsp <= '{ST_UPDATED, 3'd0, EV_NONE};
                        r_i   <= '0;
                        r_k   <= '0;
                        r_sum <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_req.operation != OP_SELECT) begin
                        r_state <= S_OUT;
                        if (r_req.operation <= OP_HLTH_FAIL &&
                                {1'b0, r_req.target_backend} < w_n) begin
                            case (r_req.operation)
                                OP_SUCCESS: begin
                                    if (r_active[r_req.target_backend] != 16'd0)
                                        r_active[r_req.target_backend] <=
                                            r_active[r_req.target_backend] - 16'd1;
                                end
                                OP_FAILURE: begin
                                    if (r_active[r_req.target_backend] != 16'd0)
                                        r_active[r_req.target_backend] <=
                                            r_active[r_req.target_backend] - 16'd1;
                                    if (r_total[r_req.target_backend] != '1)
                                        r_total[r_req.target_backend] <=
                                            r_total[r_req.target_backend] + 32'd1;
                                    if (((r_total[r_req.target_backend] != '1) ?
                                            r_total[r_req.target_backend] + 32'd1 :
                                            r_total[r_req.target_backend]) >=
                                            {16'd0, r_thresh}) begin
                                        if (r_healthy[r_req.target_backend])
                                            r_rsp.health_event <= EV_DOWN;
                                        r_healthy[r_req.target_backend] <= 1'b0;
                                    end
                                end
                                OP_HLTH_PASS: begin
                                    r_consec[r_req.target_backend] <= '0;
                                    if (!r_healthy[r_req.target_backend]) begin
                                        r_healthy[r_req.target_backend] <= 1'b1;
                                        r_rsp.health_event <= EV_UP;
                                    end
                                end
                                OP_HLTH_FAIL: begin
                                    if (r_consec[r_req.target_backend] != '1)
                                        r_consec[r_req.target_backend] <=
                                            r_consec[r_req.target_backend] + 16'd1;
                                    if (r_total[r_req.target_backend] != '1)
                                        r_total[r_req.target_backend] <=
                                            r_total[r_req.target_backend] + 32'd1;
                                    if (r_healthy[r_req.target_backend] &&
                                            ((r_consec[r_req.target_backend] != '1) ?
                                            r_consec[r_req.target_backend] + 16'd1 :
                                            r_consec[r_req.target_backend]) >=
                                            r_thresh) begin
                                        r_healthy[r_req.target_backend] <= 1'b0;
                                        r_rsp.health_event <= EV_DOWN;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end else if (!w_any) begin
                        r_rsp.status <= ST_NONE;
                        r_state <= S_OUT;
                    end else begin
                        r_rsp.status <= ST_SELECTED;
                        r_best <= w_first;
                        case (r_strategy)
                            STRAT_RR: begin
                                r_i <= (w_n == 4'd1) ? 4'd0 :
                                    CNT_W'({1'b0, r_rot[IDX_W-1:0]} % 4'd1);
                                r_state <= S_WDIV;
                                r_sum <= SUM_W'(w_n);
                                r_div_start <= 1'b1;
                            end
                            STRAT_LC: begin
                                r_i <= CNT_W'(w_first) + 4'd1;
                                r_state <= S_PICK;
                            end
                            STRAT_WRR: begin
                                r_i <= '0;
                                r_state <= S_WSUM;
                            end
                            default: begin
                                r_active[w_first] <= (r_active[w_first] != '1) ?
                                    r_active[w_first] + 16'd1 : r_active[w_first];
                                r_rsp.chosen_backend <= w_first;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_WSUM: begin
                    if (r_i == w_n) begin
                        if (r_sum == '0) begin
                            r_active[r_best] <= (r_active[r_best] != '1) ?
                                r_active[r_best] + 16'd1 : r_active[r_best];
                            r_rsp.chosen_backend <= r_best;
                            r_state <= S_OUT;
                        end else begin
                            r_div_start <= 1'b1;
                            r_state <= S_WDIV;
                        end
                    end else begin
                        if (r_healthy[w_i])
                            r_sum <= r_sum + SUM_W'(w_wt);
                        r_i <= r_i + 4'd1;
                    end
                end
                S_WDIV: begin
                    if (w_div.done) begin
                        if (r_strategy == STRAT_RR) begin
                            r_i <= CNT_W'(w_div.remainder);
                            r_k <= '0;
                            r_state <= S_PICK;
                        end else begin
                            r_pos <= w_div.remainder;
                            r_rot <= w_rot1;
                            r_sum <= '0;
                            r_i <= '0;
                            r_state <= S_WWALK;
                        end
                    end
                end
                S_WWALK: begin
                    if (r_i == w_n) begin
                        r_active[r_best] <= (r_active[r_best] != '1) ?
                            r_active[r_best] + 16'd1 : r_active[r_best];
                        r_rsp.chosen_backend <= r_best;
                        r_state <= S_OUT;
                    end else if (r_healthy[w_i] &&
                            r_pos < r_sum + SUM_W'(w_wt)) begin
                        r_active[w_i] <= (r_active[w_i] != '1) ?
                            r_active[w_i] + 16'd1 : r_active[w_i];
                        r_rsp.chosen_backend <= w_i;
                        r_state <= S_OUT;
                    end else begin
                        if (r_healthy[w_i])
                            r_sum <= r_sum + SUM_W'(w_wt);
                        r_i <= r_i + 4'd1;
                    end
                end
                S_PICK: begin
                    if (r_strategy == STRAT_RR) begin
                        // r_i holds the index of the current probe.
                        if (r_k == w_n) begin
                            r_active[r_best] <= (r_active[r_best] != '1) ?
                                r_active[r_best] + 16'd1 : r_active[r_best];
                            r_rsp.chosen_backend <= r_best;
                            r_state <= S_OUT;
                        end else begin
                            r_rot <= w_rot1;
                            r_k <= r_k + 4'd1;
                            r_i <= (w_rot1 == '1) ? '0 : w_rr_idx;
                            if (r_healthy[w_i]) begin
                                r_active[w_i] <= (r_active[w_i] != '1) ?
                                    r_active[w_i] + 16'd1 : r_active[w_i];
                                r_rsp.chosen_backend <= w_i;
                                r_state <= S_OUT;
                            end
                        end
                    end else begin
                        if (r_i >= w_n) begin
                            r_active[r_best] <= (r_active[r_best] != '1) ?
                                r_active[r_best] + 16'd1 : r_active[r_best];
                            r_rsp.chosen_backend <= r_best;
                            r_state <= S_OUT;
                        end else begin
                            if (r_healthy[w_i] && r_active[w_i] < r_active[r_best])
                                r_best <= w_i;
                            r_i <= r_i + 4'd1;
                        end
                    end
                end
                S_OUT: begin
                    if (m_rsp.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_rsp.valid |-> !s_req.ready)
        else $error("request accepted while a response is pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_rsp.valid && m_rsp.data.status != ST_SELECTED) |->
            m_rsp.data.chosen_backend == 3'd0)
        else $error("chosen backend set without a selection");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_rsp.valid && m_rsp.data.status == ST_SELECTED) |->
            m_rsp.data.health_event == EV_NONE)
        else $error("health event on a select");
endmodule

>>> hw/rtl/bsh_mod.sv
// ----------------------------------------------------------------------------
// Serial modulo unit
// Computes a 32-bit value modulo a small divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module bsh_mod import bsh_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [31:0]      r_dvd;
    logic [SUM_W:0]   r_rem;
    logic [SUM_W-1:0] r_dvs;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [SUM_W+1:0] n_shift;
    logic [SUM_W:0]   n_rem;

    always_comb begin
        n_shift = {r_rem, r_dvd[31]};
        if (n_shift >= {2'b00, r_dvs}) begin
            n_rem = (SUM_W+1)'(n_shift - {2'b00, r_dvs});
        end else begin
            n_rem = n_shift[SUM_W:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_dvd  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[30:0], 1'b0};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem[SUM_W-1:0];
endmodule

>>> bench/bsh_tb_scoreboard.sv
// ----------------------------------------------------------------------------
// Backend selector scoreboard
// Predicts the response of each accepted request from a private copy of the
// selector state and checks responses in order against the predictions.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class bsh_scoreboard;
    logic [1:0]  strategy;
    logic [15:0] threshold;
    logic [3:0]  count_reg;
    logic [31:0] weights;
    bit          healthy [8];
    logic [15:0] active [8];
    logic [31:0] total_fail [8];
    logic [15:0] consec_fail [8];
    logic [31:0] rotation;
    bsh_pkg::t_rsp pending [$];
    int errors;
    int mismatches;

    function void reset_state();
        strategy = bsh_pkg::STRAT_RR;
        threshold = 16'd3;
        count_reg = 4'd8;
        weights = 32'h1111_1111;
        for (int i = 0; i < 8; i++) begin
            healthy[i] = 1'b1;
            active[i] = '0;
            total_fail[i] = '0;
            consec_fail[i] = '0;
        end
        rotation = '0;
        pending.delete();
        errors = 0;
        mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
        case (idx)
            bsh_pkg::CFG_STRATEGY:  strategy = value[1:0];
            bsh_pkg::CFG_THRESHOLD: threshold = value[15:0];
            bsh_pkg::CFG_COUNT:     count_reg = value[3:0];
            default:                weights = value;
        endcase
    endfunction

    function int used_count();
        if (count_reg == 0) return 1;
        if (count_reg > 8) return 8;
        return int'(count_reg);
    endfunction

    function int first_healthy(int n);
        for (int i = 0; i < n; i++) if (healthy[i]) return i;
        return 0;
    endfunction

    function int choose_backend(int n);
        int best;
        logic [31:0] sum;
        logic [31:0] pos;
        logic [31:0] acc;
        int idx;
        best = first_healthy(n);
        sum = 0;
        acc = 0;
        if (strategy == bsh_pkg::STRAT_RR) begin
            for (int k = 0; k < n; k++) begin
                idx = (rotation + 1) % n;
                rotation = rotation + 1;
                if (healthy[idx]) return idx;
            end
        end else if (strategy == bsh_pkg::STRAT_LC) begin
            for (int i = best + 1; i < n; i++)
                if (healthy[i] && active[i] < active[best]) best = i;
        end else if (strategy == bsh_pkg::STRAT_WRR) begin
            for (int i = 0; i < n; i++) if (healthy[i]) sum += weights[4*i +: 4];
            if (sum == 0) return best;
            pos = rotation % sum;
            rotation = rotation + 1;
            for (int i = 0; i < n; i++) begin
                if (healthy[i]) begin
                    acc += weights[4*i +: 4];
                    if (pos < acc) return i;
                end
            end
        end
        return best;
    endfunction

    function void note_request(bsh_pkg::t_req req);
        bsh_pkg::t_rsp rsp;
        int n;
        int t;
        bit any;
        n = used_count();
        t = req.target_backend;
        rsp = '{status: bsh_pkg::ST_UPDATED, chosen_backend: 3'd0,
                health_event: bsh_pkg::EV_NONE};
        any = 0;
        if (req.operation == bsh_pkg::OP_SELECT) begin
            for (int i = 0; i < n; i++) if (healthy[i]) any = 1;
            if (!any) begin
                rsp.status = bsh_pkg::ST_NONE;
            end else begin
                rsp.chosen_backend = 3'(choose_backend(n));
                if (active[rsp.chosen_backend] != 16'hFFFF)
                    active[rsp.chosen_backend]++;
                rsp.status = bsh_pkg::ST_SELECTED;
            end
        end else if (req.operation <= bsh_pkg::OP_HLTH_FAIL && t < n) begin
            if (req.operation == bsh_pkg::OP_SUCCESS || req.operation == bsh_pkg::OP_FAILURE)
                if (active[t] != 0) active[t]--;
            if (req.operation == bsh_pkg::OP_FAILURE) begin
                if (total_fail[t] != 32'hFFFF_FFFF) total_fail[t]++;
                if (total_fail[t] >= threshold) begin
                    if (healthy[t]) rsp.health_event = bsh_pkg::EV_DOWN;
                    healthy[t] = 0;
                end
            end else if (req.operation == bsh_pkg::OP_HLTH_PASS) begin
                consec_fail[t] = 0;
                if (!healthy[t]) begin
                    healthy[t] = 1;
                    rsp.health_event = bsh_pkg::EV_UP;
                end
            end else if (req.operation == bsh_pkg::OP_HLTH_FAIL) begin
                if (consec_fail[t] != 16'hFFFF) consec_fail[t]++;
                if (total_fail[t] != 32'hFFFF_FFFF) total_fail[t]++;
                if (healthy[t] && consec_fail[t] >= threshold) begin
                    healthy[t] = 0;
                    rsp.health_event = bsh_pkg::EV_DOWN;
                end
            end
        end
        pending = {pending, rsp};
    endfunction

    function void check_response(bsh_pkg::t_rsp got);
        bsh_pkg::t_rsp want;
        if (pending.size() == 0) begin
            errors++;
            if (mismatches++ < 10) $display("Unexpected response %p", got);
            return;
        end
        want = pending.pop_front();
        if (got.status !== want.status || got.chosen_backend !== want.chosen_backend
                || got.health_event !== want.health_event) begin
            errors++;
            if (mismatches++ < 10) $display("Response mismatch: expected %p, got %p", want, got);
        end
    endfunction
endclass

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// Backend selector testbench
// Drives select, completion and health requests under all strategies and
// several register settings with random idling on both channels, and checks
// every response against the scoreboard's prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import bsh_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    int          src_idle_pct;
    int          snk_stall_pct;
    int          cycle_count;
    bit          finished;

    bsh_req_if s_req ();
    bsh_rsp_if m_rsp ();

    bsh_scoreboard board;

    backend_selector_with_health u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_req      (s_req.sink),
        .m_rsp      (m_rsp.source)
    );

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        s_req.valid = 1'b0;
        s_req.data = '0;
        m_rsp.ready = 1'b0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        cycle_count = 0;
        finished = 0;
        board = new();
        board.reset_state();
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000 && !finished) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_rsp.valid && m_rsp.ready) board.check_response(m_rsp.data);
        m_rsp.ready <= i_rst_n && ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic send_request(logic [2:0] op, logic [2:0] target);
        while ($urandom_range(99) < src_idle_pct) begin
            s_req.valid <= 1'b0;
            @(posedge i_clk);
        end
        s_req.valid <= 1'b1;
        s_req.data <= '{operation: op, target_backend: target};
        @(posedge i_clk);
        while (!s_req.ready) @(posedge i_clk);
        board.note_request('{operation: op, target_backend: target});
    endtask

    task automatic drain();
        s_req.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        board.write_reg(idx, value);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(int items);
        logic [2:0] op;
        int r;
        for (int k = 0; k < items; k++) begin
            r = $urandom_range(99);
            if (r < 40) op = OP_SELECT;
            else if (r < 55) op = OP_SUCCESS;
            else if (r < 68) op = OP_FAILURE;
            else if (r < 82) op = OP_HLTH_PASS;
            else if (r < 96) op = OP_HLTH_FAIL;
            else op = 3'($urandom_range(7, 5));
            send_request(op, 3'($urandom_range(7)));
        end
    endtask

    initial begin
        logic [1:0] strat;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every operation, extremes of target and unknown codes.
        for (int t = 0; t < 8; t++) send_request(OP_SELECT, 3'(t));
        send_request(OP_SUCCESS, 3'd7);
        send_request(OP_SUCCESS, 3'd7);
        send_request(OP_HLTH_FAIL, 3'd0);
        send_request(OP_HLTH_FAIL, 3'd0);
        send_request(OP_HLTH_FAIL, 3'd0);
        send_request(OP_HLTH_FAIL, 3'd0);
        send_request(OP_SELECT, 3'd0);
        send_request(OP_HLTH_PASS, 3'd0);
        send_request(OP_FAILURE, 3'd1);
        send_request(OP_FAILURE, 3'd1);
        send_request(OP_FAILURE, 3'd1);
        send_request(OP_FAILURE, 3'd1);
        send_request(3'd5, 3'd2);
        send_request(3'd7, 3'd5);
        drain();

        // Out-of-range target, a single backend going down, then no healthy one.
        write_reg(CFG_COUNT, 32'd1);
        write_reg(CFG_THRESHOLD, 32'd1);
        send_request(OP_HLTH_FAIL, 3'd4);
        send_request(OP_HLTH_FAIL, 3'd0);
        send_request(OP_SELECT, 3'd0);
        send_request(OP_HLTH_PASS, 3'd0);
        drain();
        write_reg(CFG_COUNT, 32'd0);
        write_reg(CFG_STRATEGY, 32'd3);
        send_request(OP_SELECT, 3'd0);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin src_idle_pct = 0; snk_stall_pct = 0; end
                1: begin src_idle_pct = 45; snk_stall_pct = 0; end
                2: begin src_idle_pct = 0; snk_stall_pct = 45; end
                default: begin src_idle_pct = 12; snk_stall_pct = 12; end
            endcase
            strat = (ph < 9) ? 2'(ph % 3) : 2'(ph - 9 + 1);
            write_reg(CFG_STRATEGY, {30'd0, strat});
            case (ph % 3)
                0: write_reg(CFG_THRESHOLD, 32'hFFFF);
                1: write_reg(CFG_THRESHOLD, 32'($urandom_range(2, 6)));
                default: write_reg(CFG_THRESHOLD, 32'd1);
            endcase
            write_reg(CFG_COUNT, (ph == 5) ? 32'd15 : 32'($urandom_range(1, 8)));
            case (ph % 4)
                0: write_reg(CFG_WEIGHTS, 32'hFFFF_FFFF);
                1: write_reg(CFG_WEIGHTS, 32'd0);
                default: write_reg(CFG_WEIGHTS, $urandom);
            endcase
            random_phase(55);
            drain();
        end

        finished = 1;
        if (board.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
